// ===== hdl/sao_pkg.sv =====
// Shared types and constants for the sample adaptive offset filter.
package sao_pkg;

    localparam int unsigned SAMPLE_W   = 10;
    localparam int unsigned BAND_SHIFT = 10 - 5;
    localparam int unsigned OFF_W      = 6;
    localparam int unsigned NUM_OFF    = 5;
    localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = 10'h3FF;

    // Configuration register indexes
    localparam logic [2:0] REG_MODE     = 3'd0;
    localparam logic [2:0] REG_BAND_POS = 3'd1;
    localparam logic [2:0] REG_WIDTH    = 3'd2;
    localparam logic [2:0] REG_OFF0     = 3'd3;
    localparam logic [2:0] REG_OFF1     = 3'd4;
    localparam logic [2:0] REG_OFF2     = 3'd5;
    localparam logic [2:0] REG_OFF3     = 3'd6;
    localparam logic [2:0] REG_OFF4     = 3'd7;

    // Filter modes
    localparam logic [2:0] MODE_BAND = 3'd0;
    localparam logic [2:0] MODE_HOR  = 3'd1;
    localparam logic [2:0] MODE_VER  = 3'd2;
    localparam logic [2:0] MODE_D135 = 3'd3;
    localparam logic [2:0] MODE_D45  = 3'd4;

    typedef struct packed {
        logic [2:0]                    mode;
        logic [4:0]                    band_pos;
        logic [NUM_OFF-1:0][OFF_W-1:0] offs;
    } t_cfg;

    // nb[row][col]: rows above2, above1, current; columns left, center, right
    typedef struct packed {
        logic [2:0][2:0][SAMPLE_W-1:0] nb;
    } t_win;

endpackage

// ===== hdl/sao_ram.sv =====
// Generic single-clock RAM, one write port and one registered read port.
module sao_ram #(
    parameter int unsigned WIDTH = 10,
    parameter int unsigned DEPTH = 130
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // read-first: a read at the written address returns the old word
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/sao_offset.sv =====
// Band and edge offset selection, add and clip for one center sample.
module sao_offset (
    input  sao_pkg::t_cfg                  i_cfg,
    input  sao_pkg::t_win                  i_win,
    output logic [sao_pkg::SAMPLE_W-1:0]   o_sample
);

    logic [sao_pkg::SAMPLE_W-1:0] c;
    logic [sao_pkg::SAMPLE_W-1:0] a;
    logic [sao_pkg::SAMPLE_W-1:0] b;
    logic [2:0]                   edge_idx;
    logic [4:0]                   band_diff;
    logic [sao_pkg::OFF_W-1:0]    off;
    logic [11:0]                  sum;

    always_comb begin
        c = i_win.nb[1][1];
        a = i_win.nb[1][0];
        b = i_win.nb[1][2];
        case (i_cfg.mode)
            sao_pkg::MODE_VER: begin
                a = i_win.nb[0][1];
                b = i_win.nb[2][1];
            end
            sao_pkg::MODE_D135: begin
                a = i_win.nb[0][0];
                b = i_win.nb[2][2];
            end
            sao_pkg::MODE_D45: begin
                a = i_win.nb[0][2];
                b = i_win.nb[2][0];
            end
            default: begin
                a = i_win.nb[1][0];
                b = i_win.nb[1][2];
            end
        endcase

        // category index: 2 + sign(c-a) + sign(c-b), in 0..4
        edge_idx = 3'd2 + {2'b00, c > a} - {2'b00, c < a}
                        + {2'b00, c > b} - {2'b00, c < b};

        band_diff = c[sao_pkg::SAMPLE_W-1:sao_pkg::BAND_SHIFT] - i_cfg.band_pos;

        off = '0;
        case (i_cfg.mode)
            sao_pkg::MODE_BAND: begin
                if (band_diff[4:2] == 3'd0) begin
                    off = i_cfg.offs[band_diff[1:0]];
                end
            end
            sao_pkg::MODE_HOR, sao_pkg::MODE_VER,
            sao_pkg::MODE_D135, sao_pkg::MODE_D45: begin
                off = i_cfg.offs[edge_idx];
            end
            default: begin
                off = '0;
            end
        endcase

        sum = {2'b00, c} + {{(12 - sao_pkg::OFF_W){off[sao_pkg::OFF_W-1]}}, off};
        if (sum[11]) begin
            o_sample = '0;
        end else if (sum[10:0] > {1'b0, sao_pkg::SAMPLE_MAX}) begin
            o_sample = sao_pkg::SAMPLE_MAX;
        end else begin
            o_sample = sum[sao_pkg::SAMPLE_W-1:0];
        end
    end

endmodule

// ===== hdl/sao_band_edge_offset_filter.sv =====
// Top level of the 10-bit sample adaptive offset filter with line stores.
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+--------------------------------
//  input    | i_in_valid / o_in_stall    | i_sample_in, i_block_start
//  output   | o_out_valid / i_out_stall  | o_sample_out, o_row_end
//  config   | i_cfg_we                   | i_cfg_addr, i_cfg_data
//
//  One sample per clock sustained while the output does not stall. The
//  sample that completes a 3x3 window waits in stage A for the line store
//  read; window update, offset and clip then go into the output register.
//  The line stores are read-modify-write memories; a back-to-back access
//  to the same column is covered by a one-entry forward register.
//  Reset is synchronous, active low; it clears counters, window and valid
//  flags and needs no clearing pass. Output stall holds the result and
//  the pending stage; input stall rises only while both are full.
module sao_band_edge_offset_filter #(
    parameter int unsigned MAX_LINE_WIDTH = 128
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [9:0]  i_sample_in,
    input  logic        i_block_start,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [9:0]  o_sample_out,
    output logic        o_row_end,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_addr,
    input  logic [7:0]  i_cfg_data
);

    localparam int unsigned DEPTH = MAX_LINE_WIDTH + 2;
    localparam int unsigned CW    = $clog2(DEPTH);
    localparam logic [CW-1:0] MAXW = CW'(MAX_LINE_WIDTH);
    localparam logic [8:0]    MAXW9 = 9'(MAX_LINE_WIDTH);

    // configuration registers
    logic [2:0]  r_mode;
    logic [4:0]  r_band_pos;
    logic [7:0]  r_line_width;
    logic [sao_pkg::NUM_OFF-1:0][sao_pkg::OFF_W-1:0] r_offs;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= sao_pkg::MODE_BAND;
            r_band_pos   <= '0;
            r_line_width <= 8'd128;
            r_offs       <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                sao_pkg::REG_MODE:     r_mode       <= i_cfg_data[2:0];
                sao_pkg::REG_BAND_POS: r_band_pos   <= i_cfg_data[4:0];
                sao_pkg::REG_WIDTH:    r_line_width <= i_cfg_data;
                sao_pkg::REG_OFF0:     r_offs[0]    <= i_cfg_data[5:0];
                sao_pkg::REG_OFF1:     r_offs[1]    <= i_cfg_data[5:0];
                sao_pkg::REG_OFF2:     r_offs[2]    <= i_cfg_data[5:0];
                sao_pkg::REG_OFF3:     r_offs[3]    <= i_cfg_data[5:0];
                sao_pkg::REG_OFF4:     r_offs[4]    <= i_cfg_data[5:0];
                default:               r_mode       <= r_mode;
            endcase
        end
    end

    // effective row width: zero taken as one, saturate at MAX_LINE_WIDTH
    logic [CW-1:0] eff_w;
    always_comb begin
        if (r_line_width == 8'd0) begin
            eff_w = CW'(1);
        end else if ({1'b0, r_line_width} > MAXW9) begin
            eff_w = MAXW;
        end else begin
            eff_w = CW'(r_line_width);
        end
    end

    // pipeline control
    logic in_acc;
    logic a_adv;
    logic out_acc;

    logic                 r_a_valid;
    logic [9:0]           r_a_sample;
    logic [CW-1:0]        r_a_col;
    logic [7:0]           r_a_row;
    logic                 r_b_valid;
    logic [9:0]           r_b_sample;
    logic                 r_b_row_end;

    assign out_acc    = r_b_valid && !i_out_stall;
    assign a_adv      = r_a_valid && (!r_b_valid || !i_out_stall);
    assign o_in_stall = r_a_valid && !a_adv;
    assign in_acc     = i_in_valid && !o_in_stall;

    // position counters of the incoming sample
    logic [CW-1:0] r_col;
    logic [7:0]    r_row;
    logic [CW-1:0] col;
    logic [7:0]    row;
    logic [CW-1:0] n_col;
    logic [7:0]    n_row;

    always_comb begin
        col = i_block_start ? '0 : r_col;
        row = i_block_start ? 8'd0 : r_row;
        if (col >= eff_w + CW'(1)) begin
            n_col = '0;
            n_row = (row == 8'd255) ? row : row + 8'd1;
        end else begin
            n_col = col + CW'(1);
            n_row = row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (in_acc) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    // stage A: sample waits here while its line store words are read
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (in_acc) begin
            r_a_valid <= 1'b1;
        end else if (a_adv) begin
            r_a_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_a_sample <= i_sample_in;
            r_a_col    <= col;
            r_a_row    <= row;
        end
    end

    // line stores: read at accept, write back when stage A advances
    logic [9:0] older_q;
    logic [9:0] newer_q;
    logic [9:0] top;
    logic [9:0] mid;

    sao_ram #(
        .WIDTH (10),
        .DEPTH (DEPTH)
    ) u_older (
        .i_clk   (i_clk),
        .i_we    (a_adv),
        .i_waddr (r_a_col),
        .i_wdata (mid),
        .i_re    (in_acc),
        .i_raddr (col),
        .o_rdata (older_q)
    );

    sao_ram #(
        .WIDTH (10),
        .DEPTH (DEPTH)
    ) u_newer (
        .i_clk   (i_clk),
        .i_we    (a_adv),
        .i_waddr (r_a_col),
        .i_wdata (r_a_sample),
        .i_re    (in_acc),
        .i_raddr (col),
        .o_rdata (newer_q)
    );

    // forward a write that lands on the column being read in the same cycle;
    // drop the flag once stage A empties
    logic       r_fwd;
    logic [9:0] r_fwd_older;
    logic [9:0] r_fwd_newer;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd <= 1'b0;
        end else if (in_acc) begin
            r_fwd <= a_adv && (r_a_col == col);
        end else if (a_adv) begin
            r_fwd <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_fwd_older <= mid;
            r_fwd_newer <= r_a_sample;
        end
    end

    assign top = r_fwd ? r_fwd_older : older_q;
    assign mid = r_fwd ? r_fwd_newer : newer_q;

    // window of the two previous columns
    logic [5:0][9:0] r_wc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wc <= '0;
        end else if (a_adv) begin
            r_wc[0] <= r_wc[1];
            r_wc[1] <= top;
            r_wc[2] <= r_wc[3];
            r_wc[3] <= mid;
            r_wc[4] <= r_wc[5];
            r_wc[5] <= r_a_sample;
        end
    end

    sao_pkg::t_win win;
    sao_pkg::t_cfg cfg;
    logic [9:0]    res_sample;
    logic          res_ok;
    logic          res_end;

    always_comb begin
        win.nb[0][0] = r_wc[0];
        win.nb[0][1] = r_wc[1];
        win.nb[0][2] = top;
        win.nb[1][0] = r_wc[2];
        win.nb[1][1] = r_wc[3];
        win.nb[1][2] = mid;
        win.nb[2][0] = r_wc[4];
        win.nb[2][1] = r_wc[5];
        win.nb[2][2] = r_a_sample;
        cfg.mode     = r_mode;
        cfg.band_pos = r_band_pos;
        cfg.offs     = r_offs;
    end

    sao_offset u_offset (
        .i_cfg    (cfg),
        .i_win    (win),
        .o_sample (res_sample)
    );

    // interior positions only: third row on, columns 2..w+1
    assign res_ok  = (r_a_row >= 8'd2) && (r_a_col >= CW'(2))
                     && (r_a_col <= eff_w + CW'(1));
    assign res_end = (r_a_col == eff_w + CW'(1));

    // stage B: output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (a_adv) begin
            r_b_valid <= res_ok;
        end else if (out_acc) begin
            r_b_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_adv) begin
            r_b_sample  <= res_sample;
            r_b_row_end <= res_end;
        end
    end

    assign o_out_valid  = r_b_valid;
    assign o_sample_out = r_b_sample;
    assign o_row_end    = r_b_row_end;

    // forwarding only ever applies to a sample held in stage A
    assert property (@(posedge i_clk) disable iff (!i_rst_n) r_fwd |-> r_a_valid)
        else $error("forward flag set with stage A empty");

    // an empty stage A never stalls the input
    assert property (@(posedge i_clk) disable iff (!i_rst_n) !r_a_valid |-> !o_in_stall)
        else $error("input stalled with stage A empty");

    // an accepted transaction occupies stage A in the next cycle
    assert property (@(posedge i_clk) disable iff (!i_rst_n) in_acc |=> r_a_valid)
        else $error("accepted transaction lost before stage A");

    // a held result is not overwritten while the output stalls
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_b_valid && i_out_stall) |-> !a_adv)
        else $error("stage A advanced into a stalled output register");

endmodule

// ===== bench/tb_sao_band_edge_offset_filter.sv =====
// Self-checking SAO filter testbench: directed and random blocks checked by a built-in predictor.
module tb_sao_band_edge_offset_filter;

    localparam int unsigned MAX_W       = 128;
    localparam int unsigned DEPTH       = MAX_W + 2;
    localparam int unsigned NUM_PHASES  = 16;
    localparam int unsigned LONG_HOLD   = 400;
    localparam int unsigned DRAIN_CYC   = 8;
    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int unsigned MAX_PRINTED = 40;

    // Phases with a special purpose in the random part
    localparam int unsigned PH_WIDE        = 3;
    localparam int unsigned PH_HOLD        = 4;
    localparam int unsigned PH_SHRINK_FROM = 6;
    localparam int unsigned PH_SHRINK      = 7;
    localparam int unsigned PH_TALL        = 13;

    typedef enum int unsigned {PACE_NONE, PACE_TX, PACE_RX, PACE_BOTH, PACE_HOLD} t_pace;

    typedef struct packed {
        logic [sao_pkg::SAMPLE_W-1:0] pix;
        logic                         sob;
    } t_feed_item;

    typedef struct packed {
        logic [sao_pkg::SAMPLE_W-1:0] pix;
        logic                         last;
    } t_filt_res;

    // DUT ports; the inputs are known from time zero
    logic                         i_clk         = 1'b0;
    logic                         i_rst_n       = 1'b0;
    logic                         i_in_valid    = 1'b0;
    logic                         o_in_stall;
    logic [sao_pkg::SAMPLE_W-1:0] i_sample_in   = '0;
    logic                         i_block_start = 1'b0;
    logic                         o_out_valid;
    logic                         i_out_stall   = 1'b0;
    logic [sao_pkg::SAMPLE_W-1:0] o_sample_out;
    logic                         o_row_end;
    logic                         i_cfg_we      = 1'b0;
    logic [2:0]                   i_cfg_addr    = '0;
    logic [7:0]                   i_cfg_data    = '0;

    // Stimulus and bookkeeping
    t_feed_item  sample_feed [$];
    t_filt_res   filtered_due [$];
    t_feed_item  next_item;
    t_pace       pace = PACE_NONE;
    logic        in_taken = 1'b0;
    logic [4:0]  band_now = '0;
    logic [5:0]  next_off [0:sao_pkg::NUM_OFF-1];
    int unsigned samples_fed = 0;
    int unsigned samples_taken = 0;
    int unsigned pix_checked = 0;
    int unsigned reg_writes = 0;
    int unsigned mismatches = 0;
    int unsigned hold_count = 0;
    int unsigned cycles = 0;

    // Predictor state: mirrored registers, line stores, window, position
    logic [2:0]                   cfg_mode;
    logic [4:0]                   cfg_band;
    logic [7:0]                   cfg_width;
    logic signed [5:0]            cfg_off [0:sao_pkg::NUM_OFF-1];
    logic [sao_pkg::SAMPLE_W-1:0] store_old [0:DEPTH-1];
    logic [sao_pkg::SAMPLE_W-1:0] store_new [0:DEPTH-1];
    logic [sao_pkg::SAMPLE_W-1:0] win_col [0:5];
    int unsigned                  col_pos;
    int unsigned                  row_pos;

    sao_band_edge_offset_filter #(
        .MAX_LINE_WIDTH(MAX_W)
    ) i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_sample_in   (i_sample_in),
        .i_block_start (i_block_start),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_sample_out  (o_sample_out),
        .o_row_end     (o_row_end),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_data    (i_cfg_data)
    );

    always #6 i_clk = ~i_clk;

    function automatic bit chance(input int unsigned pct);
        return $urandom_range(99) < pct;
    endfunction

    function automatic int unsigned idle_pct(input t_pace pc, input bit rx_side);
        case (pc)
            PACE_TX:   return rx_side ? 0 : 58;
            PACE_RX:   return rx_side ? 58 : 0;
            PACE_BOTH: return 27;
            default:   return 0;
        endcase
    endfunction

    // Edge category -2..2 mapped to offset index 0..4
    function automatic int edge_class(input logic [sao_pkg::SAMPLE_W-1:0] c,
                                      input logic [sao_pkg::SAMPLE_W-1:0] a,
                                      input logic [sao_pkg::SAMPLE_W-1:0] b);
        int sa, sb;
        sa = (c > a) ? 1 : ((c < a) ? -1 : 0);
        sb = (c > b) ? 1 : ((c < b) ? -1 : 0);
        return sa + sb + 2;
    endfunction

    function automatic logic [5:0] pick_offset();
        int t;
        case ($urandom_range(19))
            0:       return 6'd31;
            1:       return 6'h21;   // -31
            2:       return 6'h20;   // -32, just outside the stated range
            default: begin
                t = $urandom_range(62);
                t = t - 31;
                return t[5:0];
            end
        endcase
    endfunction

    // Mostly near a block base (to hit equal neighbours) or in or just past the offset bands
    function automatic logic [sao_pkg::SAMPLE_W-1:0] pick_sample(input int unsigned base_v,
                                                                 input logic [4:0] band);
        int v;
        logic [4:0] b;
        case ($urandom_range(9))
            0, 1, 2, 3: begin
                v = base_v;
                v = v + $urandom_range(4);
                v = v - 2;
            end
            4, 5:    v = $urandom_range(1023);
            6:       v = $urandom_range(1) ? 1023 : 0;
            default: begin
                b = band + $urandom_range(4);
                v = b * 32 + $urandom_range(31);
            end
        endcase
        if (v < 0) v = 0;
        if (v > 1023) v = 1023;
        return v[sao_pkg::SAMPLE_W-1:0];
    endfunction

    task automatic report_mismatch(input string what);
        mismatches++;
        if (mismatches <= MAX_PRINTED) $display("MISMATCH at %0t: %s", $time, what);
    endtask

    // Advance the predictor by one accepted sample; queue the filtered result if any
    task automatic filter_sample(input logic [sao_pkg::SAMPLE_W-1:0] s, input logic sob);
        int unsigned w, c;
        int off, sum;
        logic [4:0] bk;
        logic [sao_pkg::SAMPLE_W-1:0] ctr;
        logic [sao_pkg::SAMPLE_W-1:0] nb [0:2][0:2];
        t_filt_res res;
        w = (cfg_width == 0) ? 1 : ((cfg_width > MAX_W) ? MAX_W : cfg_width);
        if (sob) begin
            col_pos = 0;
            row_pos = 0;
        end
        c = col_pos;
        // rows: two above, one above, current; columns: left, center, right
        nb[0][0] = win_col[0]; nb[0][1] = win_col[1];
        nb[0][2] = (c < DEPTH) ? store_old[c] : '0;
        nb[1][0] = win_col[2]; nb[1][1] = win_col[3];
        nb[1][2] = (c < DEPTH) ? store_new[c] : '0;
        nb[2][0] = win_col[4]; nb[2][1] = win_col[5]; nb[2][2] = s;
        if (row_pos >= 2 && c >= 2 && c <= w + 1) begin
            ctr = nb[1][1];
            off = 0;
            case (cfg_mode)
                sao_pkg::MODE_BAND: begin
                    for (int k = 0; k < 4; k++) begin
                        bk = cfg_band + k;
                        if ((ctr >> sao_pkg::BAND_SHIFT) == bk) off = cfg_off[k];
                    end
                end
                sao_pkg::MODE_HOR:  off = cfg_off[edge_class(ctr, nb[1][0], nb[1][2])];
                sao_pkg::MODE_VER:  off = cfg_off[edge_class(ctr, nb[0][1], nb[2][1])];
                sao_pkg::MODE_D135: off = cfg_off[edge_class(ctr, nb[0][0], nb[2][2])];
                sao_pkg::MODE_D45:  off = cfg_off[edge_class(ctr, nb[0][2], nb[2][0])];
                default:            off = 0;  // undefined modes pass the sample through
            endcase
            sum = int'(ctr) + off;
            if (sum < 0) begin
                res.pix = '0;
            end else if (sum > sao_pkg::SAMPLE_MAX) begin
                res.pix = sao_pkg::SAMPLE_MAX;
            end else begin
                res.pix = sum[sao_pkg::SAMPLE_W-1:0];
            end
            res.last = (c == w + 1);
            filtered_due.push_back(res);
        end
        if (c < DEPTH) begin
            store_old[c] = nb[1][2];
            store_new[c] = s;
        end
        win_col[0] = nb[0][1]; win_col[1] = nb[0][2];
        win_col[2] = nb[1][1]; win_col[3] = nb[1][2];
        win_col[4] = nb[2][1]; win_col[5] = s;
        if (c + 1 >= w + 2) begin
            col_pos = 0;
            if (row_pos < 255) row_pos++;
        end else begin
            col_pos = c + 1;
        end
    endtask

    // Monitor: check results, mirror register writes, predict accepted samples
    always @(posedge i_clk) begin
        t_filt_res want;
        if (!i_rst_n) begin
            cfg_mode  = sao_pkg::MODE_BAND;
            cfg_band  = '0;
            cfg_width = MAX_W;
            for (int k = 0; k < sao_pkg::NUM_OFF; k++) cfg_off[k] = '0;
            for (int k = 0; k < 6; k++) win_col[k] = '0;
            col_pos   = 0;
            row_pos   = 0;
            in_taken <= 1'b0;
        end else begin
            if (o_out_valid === 1'b1 && i_out_stall == 1'b0) begin
                pix_checked++;
                if (filtered_due.size() == 0) begin
                    report_mismatch($sformatf("result %0d with nothing outstanding",
                                              o_sample_out));
                end else begin
                    want = filtered_due.pop_front();
                    if (o_sample_out !== want.pix)
                        report_mismatch($sformatf("sample_out %0d, want %0d",
                                                  o_sample_out, want.pix));
                    if (o_row_end !== want.last)
                        report_mismatch($sformatf("row_end %b, want %b (sample %0d)",
                                                  o_row_end, want.last, want.pix));
                end
            end
            if (i_cfg_we) begin
                reg_writes++;
                case (i_cfg_addr)
                    sao_pkg::REG_MODE:     cfg_mode  = i_cfg_data[2:0];
                    sao_pkg::REG_BAND_POS: cfg_band  = i_cfg_data[4:0];
                    sao_pkg::REG_WIDTH:    cfg_width = i_cfg_data;
                    default: cfg_off[i_cfg_addr - sao_pkg::REG_OFF0] = i_cfg_data[5:0];
                endcase
            end
            in_taken <= i_in_valid && !o_in_stall;
            if (i_in_valid && o_in_stall === 1'b0) begin
                samples_taken++;
                filter_sample(i_sample_in, i_block_start);
            end
        end
    end

    // Driver: hold the transaction while stalled, otherwise advance or idle
    always @(negedge i_clk) begin
        if (!i_in_valid || in_taken) begin
            if (sample_feed.size() != 0 && !chance(idle_pct(pace, 1'b0))) begin
                next_item = sample_feed.pop_front();
                i_in_valid    <= 1'b1;
                i_sample_in   <= next_item.pix;
                i_block_start <= next_item.sob;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Receiver: one long hold-off in the hold phase, random stalls otherwise
    always @(negedge i_clk) begin
        if (pace == PACE_HOLD && hold_count < LONG_HOLD) begin
            i_out_stall <= 1'b1;
            hold_count  <= hold_count + 1;
        end else begin
            i_out_stall <= chance(idle_pct(pace, 1'b1));
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results outstanding",
                     cycles, filtered_due.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic add_item(input logic [sao_pkg::SAMPLE_W-1:0] pix, input logic sob);
        t_feed_item it;
        it.pix = pix;
        it.sob = sob;
        sample_feed.push_back(it);
        samples_fed++;
    endtask

    task automatic queue_block(input int unsigned count, input bit mark, input bit noisy);
        int unsigned base_v;
        base_v = chance(15) ? (chance(50) ? 0 : 1023) : $urandom_range(1023);
        for (int unsigned i = 0; i < count; i++)
            add_item(pick_sample(base_v, band_now), (i == 0) ? mark : (noisy && chance(1)));
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [7:0] val);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    // Write every register; unused upper data bits carry junk
    task automatic program_regs(input logic [2:0] mode, input logic [4:0] band,
                                input logic [7:0] width);
        logic [7:0] junk;
        junk = $urandom;
        write_reg(sao_pkg::REG_MODE, {junk[7:3], mode});
        write_reg(sao_pkg::REG_BAND_POS, {junk[2:0], band});
        write_reg(sao_pkg::REG_WIDTH, width);
        for (int k = 0; k < sao_pkg::NUM_OFF; k++) begin
            junk = $urandom;
            write_reg(sao_pkg::REG_OFF0 + k, {junk[7:6], next_off[k]});
        end
    endtask

    // Wait until every sample is in and every result is out, then let the pipe drain
    task automatic settle();
        while (samples_taken != samples_fed || filtered_due.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYC) @(negedge i_clk);
    endtask

    initial begin
        int unsigned p, eff, span, rows, total, keep, got, target;
        logic [2:0] mode_now;
        logic [7:0] width_now;
        t_pace pace_next;

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Band mode across the 31/0 wrap, clipping both ways; first block has no start flag
        band_now = 5'd31;
        next_off[0] = 6'd31; next_off[1] = 6'h21; next_off[2] = 6'd0;
        next_off[3] = 6'd5;  next_off[4] = 6'h3B;
        program_regs(sao_pkg::MODE_BAND, band_now, 8'd2);
        add_item(10'd10, 1'b0);   add_item(10'd500, 1'b0);
        add_item(10'd1023, 1'b0); add_item(10'd0, 1'b0);
        add_item(10'd7, 1'b0);    add_item(10'd1023, 1'b0);
        add_item(10'd0, 1'b0);    add_item(10'd1023, 1'b0);
        add_item(10'd1023, 1'b0); add_item(10'd0, 1'b0);
        add_item(10'd512, 1'b0);  add_item(10'd3, 1'b0);
        settle();

        // Zero line width (taken as one), horizontal edge, all offsets at -32
        for (int k = 0; k < sao_pkg::NUM_OFF; k++) next_off[k] = 6'h20;
        program_regs(sao_pkg::MODE_HOR, 5'd0, 8'd0);
        add_item(10'd0, 1'b1);    add_item(10'd0, 1'b0);    add_item(10'd0, 1'b0);
        add_item(10'd512, 1'b0);  add_item(10'd1023, 1'b0); add_item(10'd512, 1'b0);
        add_item(10'd1023, 1'b0); add_item(10'd1023, 1'b0); add_item(10'd1023, 1'b0);
        settle();

        for (p = 0; p < NUM_PHASES; p++) begin
            mode_now = p[2:0];   // walk all eight mode codes, twice
            case (p % 5)
                0:       band_now = 5'd0;
                1:       band_now = 5'd31;
                default: band_now = $urandom_range(31);
            endcase
            case (p)
                PH_WIDE:        width_now = 8'd255;
                PH_TALL:        width_now = 8'd0;
                PH_SHRINK_FROM: width_now = 8'd9;
                PH_SHRINK:      width_now = 8'd4;
                default:        width_now = $urandom_range(1, 10);
            endcase
            for (int k = 0; k < sao_pkg::NUM_OFF; k++) next_off[k] = pick_offset();
            program_regs(mode_now, band_now, width_now);

            if (p == PH_HOLD) begin
                pace_next = PACE_HOLD;
            end else begin
                case (p % 4)
                    0:       pace_next = PACE_NONE;
                    1:       pace_next = PACE_TX;
                    2:       pace_next = PACE_RX;
                    default: pace_next = PACE_BOTH;
                endcase
            end
            pace = pace_next;

            eff  = (width_now == 0) ? 1 : ((width_now > MAX_W) ? MAX_W : width_now);
            span = eff + 2;
            if (p == PH_TALL) begin
                // Run the row counter past its saturation point
                queue_block(span * 258, 1'b1, 1'b0);
            end else begin
                target = (p == PH_HOLD) ? 40 : 16;
                got = 0;
                while (got < target) begin
                    rows  = (span > 12) ? 3 : $urandom_range(3, 4);
                    total = span * rows;
                    keep  = chance(10) ? $urandom_range(1, total - 1) : total;
                    // Narrow the line mid-block: continue the old block without a start flag
                    queue_block(keep, !(p == PH_SHRINK && got == 0), 1'b1);
                    got += keep;
                end
            end
            settle();
        end

        $display("Covered %0d samples, %0d filtered results, %0d register writes, %0d settings",
                 samples_taken, pix_checked, reg_writes, NUM_PHASES + 2);
        $display("All eight mode codes, widths 0..255 incl. mid-block narrowing, %0d-cycle hold",
                 LONG_HOLD);
        if (mismatches == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// ===== files.f =====
hdl/sao_pkg.sv
hdl/sao_ram.sv
hdl/sao_offset.sv
hdl/sao_band_edge_offset_filter.sv
bench/tb_sao_band_edge_offset_filter.sv
